// ===== hw/rtl/lou6502_pkg.sv =====
// ----------------------------------------------------------------------------
// lou6502_pkg
// Shared types and codes for the 6502 logical-operation addressing unit.
// ----------------------------------------------------------------------------
package lou6502_pkg;

    // Default memory address width and depth of the front-to-back queue
    localparam int ADDR_BITS_DEF = 16;
    localparam int Q_DEPTH       = 2;

    // Command codes
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_AND   = 3'd1;
    localparam logic [2:0] CMD_EOR   = 3'd2;
    localparam logic [2:0] CMD_ORA   = 3'd3;
    localparam logic [2:0] CMD_LOAD  = 3'd4;

    // Addressing mode codes
    localparam logic [3:0] MODE_IMM   = 4'd0;
    localparam logic [3:0] MODE_ZP    = 4'd1;
    localparam logic [3:0] MODE_ZP_X  = 4'd2;
    localparam logic [3:0] MODE_ABS   = 4'd3;
    localparam logic [3:0] MODE_ABS_X = 4'd4;
    localparam logic [3:0] MODE_ABS_Y = 4'd5;
    localparam logic [3:0] MODE_IND_X = 4'd6;
    localparam logic [3:0] MODE_IND_Y = 4'd7;

    // Request as seen on the input port
    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  mode;
        logic [15:0] operand;
        logic [7:0]  x_index;
        logic [7:0]  y_index;
        logic [7:0]  write_data;
    } t_in_item;

    // Result as seen on the output port
    typedef struct packed {
        logic [7:0] acc_out;
        logic       zero_out;
        logic       negative_out;
        logic       status;
    } t_out_item;

    // Class of a decoded request
    typedef enum logic [2:0] {
        K_WRITE,
        K_LOAD,
        K_IMM,
        K_DIRECT,
        K_INDIRECT,
        K_INVALID,
        K_NOP
    } t_kind;

    // Logical operation
    typedef enum logic [1:0] {
        ALU_AND,
        ALU_EOR,
        ALU_ORA
    } t_alu;

    // Decoded request handed from front to back
    typedef struct packed {
        t_kind       kind;
        t_alu        alu;
        logic [15:0] addr;   // effective address, or zero-page pointer
        logic [7:0]  y_add;  // added to the fetched pointer
        logic [7:0]  data;   // write byte, immediate or load value
    } t_op;

    // Queue fill status
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== hw/rtl/lou6502_front.sv =====
// ----------------------------------------------------------------------------
// lou6502_front
// Accepts requests and classifies them: decodes command and addressing mode,
// and forms the effective address or zero-page pointer.
// ----------------------------------------------------------------------------
module lou6502_front
    import lou6502_pkg::*;
(
    input  logic     push,
    output logic     full,
    input  t_in_item i_in_item,
    input  t_q_stat  i_q_stat,
    output logic     o_q_push,
    output t_op      o_op
);

    logic [7:0] zp;
    logic [7:0] zp_x;

    assign zp   = i_in_item.operand[7:0];
    assign zp_x = zp + i_in_item.x_index;

    // Accept while the queue has room
    assign full     = i_q_stat.full;
    assign o_q_push = push & ~i_q_stat.full;

    // Classify the request
    always_comb begin
        o_op.kind  = K_NOP;
        o_op.alu   = ALU_AND;
        o_op.addr  = i_in_item.operand;
        o_op.y_add = 8'h00;
        o_op.data  = i_in_item.write_data;

        case (i_in_item.cmd)
            CMD_WRITE: begin
                o_op.kind = K_WRITE;
            end
            CMD_AND, CMD_EOR, CMD_ORA: begin
                case (i_in_item.cmd)
                    CMD_AND: o_op.alu = ALU_AND;
                    CMD_EOR: o_op.alu = ALU_EOR;
                    default: o_op.alu = ALU_ORA;
                endcase
                case (i_in_item.mode)
                    MODE_IMM: begin
                        o_op.kind = K_IMM;
                        o_op.data = zp;
                    end
                    MODE_ZP: begin
                        o_op.kind = K_DIRECT;
                        o_op.addr = {8'h00, zp};
                    end
                    MODE_ZP_X: begin
                        o_op.kind = K_DIRECT;
                        o_op.addr = {8'h00, zp_x};
                    end
                    MODE_ABS: begin
                        o_op.kind = K_DIRECT;
                    end
                    MODE_ABS_X: begin
                        o_op.kind = K_DIRECT;
                        o_op.addr = i_in_item.operand + {8'h00, i_in_item.x_index};
                    end
                    MODE_ABS_Y: begin
                        o_op.kind = K_DIRECT;
                        o_op.addr = i_in_item.operand + {8'h00, i_in_item.y_index};
                    end
                    MODE_IND_X: begin
                        o_op.kind = K_INDIRECT;
                        o_op.addr = {8'h00, zp_x};
                    end
                    MODE_IND_Y: begin
                        o_op.kind  = K_INDIRECT;
                        o_op.addr  = {8'h00, zp};
                        o_op.y_add = i_in_item.y_index;
                    end
                    default: begin
                        o_op.kind = K_INVALID;
                    end
                endcase
            end
            CMD_LOAD: begin
                o_op.kind = K_LOAD;
                o_op.data = zp;
            end
            default: begin
                o_op.kind = K_NOP;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lou6502_queue.sv =====
// ----------------------------------------------------------------------------
// lou6502_queue
// Short queue of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
module lou6502_queue
    import lou6502_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_op,
    input  logic    i_pop,
    output t_op     o_op,
    output t_q_stat o_q_stat
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_op              r_entry [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Advance pointers with wrap and track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_op;
        end
    end

    assign o_op           = r_entry[r_rd_ptr];
    assign o_q_stat.empty = (r_count == '0);
    assign o_q_stat.full  = (r_count == CNT_W'(Q_DEPTH));

endmodule

// ===== hw/rtl/lou6502_back.sv =====
// ----------------------------------------------------------------------------
// lou6502_back
// Carries out decoded requests: writes and reads the byte memory (pointers and
// operands), updates the accumulator and flags, and holds the result register.
// ----------------------------------------------------------------------------
module lou6502_back
    import lou6502_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_stat   i_q_stat,
    input  t_op       i_op,
    output logic      o_q_pop,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_out_item,
    output logic      o_done
);

    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PTR_LO,
        S_PTR_HI,
        S_OPER
    } t_state;

    function automatic logic [7:0] alu_apply(input t_alu op, input logic [7:0] a,
                                             input logic [7:0] b);
        case (op)
            ALU_AND: alu_apply = a & b;
            ALU_EOR: alu_apply = a ^ b;
            ALU_ORA: alu_apply = a | b;
            default: alu_apply = a;
        endcase
    endfunction

    logic [7:0] r_mem [MEM_DEPTH];

    t_state     r_state, n_state;
    logic [7:0] r_acc, n_acc;
    logic       r_zero, n_zero;
    logic       r_neg, n_neg;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out;
    t_op        r_op, n_op;
    logic [7:0] r_ptr_lo, n_ptr_lo;
    logic [7:0] r_rdata;

    logic        slot_free;
    logic        rd_en;
    logic [15:0] rd_addr;
    logic        wr_en;
    logic        done;
    logic        res_status;
    logic        upd_flags;

    assign slot_free = !r_out_valid || pop;

    // Sequence requests through the single memory port
    always_comb begin
        n_state    = r_state;
        n_acc      = r_acc;
        n_op       = r_op;
        n_ptr_lo   = r_ptr_lo;
        o_q_pop    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_op.addr;
        wr_en      = 1'b0;
        done       = 1'b0;
        res_status = 1'b0;
        upd_flags  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    case (i_op.kind)
                        K_DIRECT: begin
                            o_q_pop = 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = i_op.addr;
                            n_op    = i_op;
                            n_state = S_OPER;
                        end
                        K_INDIRECT: begin
                            o_q_pop = 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = i_op.addr;
                            n_op    = i_op;
                            n_state = S_PTR_LO;
                        end
                        default: begin
                            if (slot_free) begin
                                o_q_pop = 1'b1;
                                done    = 1'b1;
                                case (i_op.kind)
                                    K_WRITE: wr_en = 1'b1;
                                    K_LOAD: begin
                                        n_acc     = i_op.data;
                                        upd_flags = 1'b1;
                                    end
                                    K_IMM: begin
                                        n_acc     = alu_apply(i_op.alu, r_acc, i_op.data);
                                        upd_flags = 1'b1;
                                    end
                                    K_INVALID: res_status = 1'b1;
                                    default: ;
                                endcase
                            end
                        end
                    endcase
                end
            end
            S_PTR_LO: begin
                // Latch pointer low byte, fetch high byte within page zero
                n_ptr_lo = r_rdata;
                rd_en    = 1'b1;
                rd_addr  = {8'h00, r_op.addr[7:0] + 8'd1};
                n_state  = S_PTR_HI;
            end
            S_PTR_HI: begin
                rd_en   = 1'b1;
                rd_addr = {r_rdata, r_ptr_lo} + {8'h00, r_op.y_add};
                n_state = S_OPER;
            end
            S_OPER: begin
                if (slot_free) begin
                    done      = 1'b1;
                    n_acc     = alu_apply(r_op.alu, r_acc, r_rdata);
                    upd_flags = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_zero = upd_flags ? (n_acc == 8'h00) : r_zero;
        n_neg  = upd_flags ? n_acc[7] : r_neg;

        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    // Hold state, accumulator, flags and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= 8'h00;
            r_zero      <= 1'b0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_zero      <= n_zero;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_ptr_lo <= n_ptr_lo;
        if (done) begin
            r_out.acc_out      <= n_acc;
            r_out.zero_out     <= n_zero;
            r_out.negative_out <= n_neg;
            r_out.status       <= res_status;
        end
    end

    // Byte memory: one access a cycle, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_op.addr[ADDR_BITS-1:0]] <= i_op.data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr[ADDR_BITS-1:0]];
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_item = r_out;
    assign o_done     = done;

endmodule

// ===== hw/rtl/logic_op_addressing_unit_6502.sv =====
// ----------------------------------------------------------------------------
// logic_op_addressing_unit_6502
// 6502 AND / EOR / ORA unit with eight addressing modes over a byte memory.
// ----------------------------------------------------------------------------
// Each request yields one result: accumulator, zero and negative flags and a
// status bit (1 for an invalid addressing mode). Requests enter a two-entry
// queue while the back end works, so push is taken whenever the queue has
// room. The back end owns one single-ported byte memory with a registered
// read and handles one request at a time: memory writes, loads, immediate,
// invalid and unused commands finish as soon as they are taken; zero-page and
// absolute modes present the address, then use the data; (zp,X) and (zp),Y
// fetch pointer low, pointer high, operand, then do the operation. A finished
// result waits in its own register until popped. Memory has no reset; reading
// a location that was never written returns an unspecified byte.
// ----------------------------------------------------------------------------
module logic_op_addressing_unit_6502
    import lou6502_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    t_op     w_front_op;
    t_op     w_queue_op;
    logic    w_q_push;
    logic    w_q_pop;
    t_q_stat w_q_stat;
    logic    w_done;

    // Decode requests
    lou6502_front u_front (
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_q_stat  (w_q_stat),
        .o_q_push  (w_q_push),
        .o_op      (w_front_op)
    );

    // Buffer decoded requests
    lou6502_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_op     (w_front_op),
        .i_pop    (w_q_pop),
        .o_op     (w_queue_op),
        .o_q_stat (w_q_stat)
    );

    // Execute requests
    lou6502_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_op       (w_queue_op),
        .o_q_pop    (w_q_pop),
        .pop        (pop),
        .empty      (empty),
        .o_out_item (o_out_item),
        .o_done     (w_done)
    );

`ifndef ASSERT_OFF
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue reports full and empty at once");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_stat.empty)
        else $error("back end took a request from an empty queue");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(w_done))
        else $error("result appeared without a finished request");

    a_done_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !empty) |-> pop)
        else $error("result overwrote one still waiting");
`endif

endmodule
